@@ src/edf_deadline_task_scheduler_unit_assert.svh @@
// Assertion macros shared by the deadline scheduler RTL.
`ifndef EDF_DEADLINE_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define EDF_DEADLINE_TASK_SCHEDULER_UNIT_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define EDFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define EDFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/edfs_pkg.sv @@
// Types and constants shared by the deadline scheduler modules.
`default_nettype none
package edfs_pkg;

  localparam int DEF_MAX_ACTIVE = 16;
  localparam int DEF_COUNT_BITS = 16;

  typedef enum logic [1:0] {
    CMD_RELEASE = 2'd0,
    CMD_DONE    = 2'd1,
    CMD_OVERDUE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NO_ID    = 2'd1,
    STS_LATE     = 2'd2,
    STS_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  task_id;
    logic [31:0] deadline;
  } slot_t;

  typedef struct packed {
    logic        ins;
    logic        rem;
    logic [7:0]  task_id;
    logic [31:0] deadline;
  } op_t;

  localparam slot_t SLOT_EMPTY = '{valid: 1'b0, task_id: 8'd0, deadline: 32'd0};

endpackage
`default_nettype wire

@@ src/edfs_cell.sv @@
// One slot of the sorted task chain: insert shifts toward the tail, remove toward the head.
`default_nettype none
module edfs_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire edfs_pkg::op_t  op,
  input  wire edfs_pkg::slot_t prev_slot,
  input  wire edfs_pkg::slot_t next_slot,
  input  wire logic           ins_in,
  input  wire logic           seen_in,
  output edfs_pkg::slot_t     slot,
  output logic                ins_out,
  output logic                seen_out
);
  import edfs_pkg::*;

  slot_t slot_next;
  logic  match;

  // The new task belongs at or before this slot.
  assign ins_out = !slot.valid || (op.deadline < slot.deadline) ||
                   ((op.deadline == slot.deadline) && (op.task_id <= slot.task_id));
  assign match    = slot.valid && (slot.task_id == op.task_id);
  assign seen_out = seen_in || match;

  always_comb begin
    slot_next = slot;
    if (op.ins) begin
      if (ins_in) begin
        slot_next = prev_slot;
      end else if (ins_out) begin
        slot_next.valid    = 1'b1;
        slot_next.task_id  = op.task_id;
        slot_next.deadline = op.deadline;
      end
    end else if (op.rem && seen_out) begin
      slot_next = next_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.task_id  <= slot_next.task_id;
    slot.deadline <= slot_next.deadline;
  end

endmodule
`default_nettype wire

@@ src/edfs_ctrl.sv @@
// Request sequencer, status decision, active count and saturating event counters.
`default_nettype none
module edfs_ctrl #(
  parameter int MAX_ACTIVE = edfs_pkg::DEF_MAX_ACTIVE,
  parameter int COUNT_BITS = edfs_pkg::DEF_COUNT_BITS,
  parameter int CNT_W      = $clog2(MAX_ACTIVE + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       cmd,
  input  wire logic [7:0]       task_id,
  input  wire logic [31:0]      deadline,
  input  wire logic [31:0]      now,
  input  wire logic             found,
  output logic                  busy,
  output logic                  done,
  output edfs_pkg::op_t         op,
  output logic [1:0]            status,
  output logic [CNT_W-1:0]      count,
  output logic [COUNT_BITS-1:0] done_total,
  output logic [COUNT_BITS-1:0] late_total
);
  import edfs_pkg::*;

  state_t      state, state_next;
  cmd_t        cmd_q;
  logic [7:0]  id_q;
  logic [31:0] dl_q;
  logic [31:0] now_q;
  logic        accept;
  logic        is_late;
  logic        is_full;
  logic        is_rem;
  status_t     status_next;
  logic        bump_done, bump_late;

  assign accept  = start && !busy;
  assign is_late = (dl_q <= now_q);
  assign is_full = (count == CNT_W'(MAX_ACTIVE));
  assign is_rem  = (cmd_q == CMD_DONE) || (cmd_q == CMD_OVERDUE);

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        busy       = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = start ? ST_EXEC : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op.ins      = busy && (cmd_q == CMD_RELEASE) && !is_late && !is_full;
    op.rem      = busy && is_rem;
    op.task_id  = id_q;
    op.deadline = dl_q;
    status_next = STS_OK;
    bump_done   = 1'b0;
    bump_late   = 1'b0;
    unique case (cmd_q)
      CMD_RELEASE: begin
        if (is_late) begin
          status_next = STS_LATE;
          bump_late   = 1'b1;
        end else if (is_full) begin
          status_next = STS_FULL;
        end
      end
      CMD_DONE: begin
        if (found) bump_done = 1'b1;
        else status_next = STS_NO_ID;
      end
      CMD_OVERDUE: begin
        if (found) bump_late = 1'b1;
        else status_next = STS_NO_ID;
      end
      CMD_QUERY: status_next = STS_OK;
      default: status_next = STS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      done_total <= '0;
      late_total <= '0;
    end else begin
      state <= state_next;
      if (op.ins) begin
        count <= count + 1'b1;
      end else if (op.rem && found) begin
        count <= count - 1'b1;
      end
      if (busy && bump_done && (done_total != '1)) done_total <= done_total + 1'b1;
      if (busy && bump_late && (late_total != '1)) late_total <= late_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(cmd);
      id_q  <= task_id;
      dl_q  <= deadline;
      now_q <= now;
    end
    if (busy) status <= status_next;
  end

endmodule
`default_nettype wire

@@ src/edf_deadline_task_scheduler_unit.sv @@
// Earliest-deadline-first scheduler: a sorted chain of task cells and its sequencer.
// A request is taken when start is high and busy is low; busy is high for one cycle after.
// The strobe done is high in the cycle after busy and marks the result of the request.
// A new request can be taken during the done cycle but not during the execute cycle,
// in which the cells of the chain shift or load in parallel.
// Synchronous reset empties the chain and clears all counts; no clearing pass is needed.
`default_nettype none
`include "edf_deadline_task_scheduler_unit_assert.svh"
module edf_deadline_task_scheduler_unit #(
  parameter int MAX_ACTIVE = edfs_pkg::DEF_MAX_ACTIVE,
  parameter int COUNT_BITS = edfs_pkg::DEF_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  task_id,
  input  wire logic [31:0] deadline,
  input  wire logic [31:0] now,
  output logic             busy,
  output logic             done,
  output logic [1:0]       status,
  output logic             head_valid,
  output logic [7:0]       head_task_id,
  output logic [31:0]      head_deadline,
  output logic [4:0]       active_count,
  output logic [15:0]      completed_count,
  output logic [15:0]      overdue_count
);
  import edfs_pkg::*;

  localparam int CNT_W = $clog2(MAX_ACTIVE + 1);

  op_t                   op;
  slot_t                 slots [MAX_ACTIVE];
  logic [MAX_ACTIVE-1:0] ins_flag;
  logic [MAX_ACTIVE-1:0] seen;
  logic [MAX_ACTIVE-1:0] valid_vec;
  logic [CNT_W-1:0]      count;
  logic [COUNT_BITS-1:0] done_total;
  logic [COUNT_BITS-1:0] late_total;

  edfs_ctrl #(
    .MAX_ACTIVE (MAX_ACTIVE),
    .COUNT_BITS (COUNT_BITS),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .task_id    (task_id),
    .deadline   (deadline),
    .now        (now),
    .found      (seen[MAX_ACTIVE-1]),
    .busy       (busy),
    .done       (done),
    .op         (op),
    .status     (status),
    .count      (count),
    .done_total (done_total),
    .late_total (late_total)
  );

  for (genvar i = 0; i < MAX_ACTIVE; i++) begin : g_cell
    slot_t prev_slot;
    slot_t next_slot;
    logic  ins_in;
    logic  seen_in;

    if (i == 0) begin : g_first
      assign prev_slot = SLOT_EMPTY;
      assign ins_in    = 1'b0;
      assign seen_in   = 1'b0;
    end else begin : g_mid
      assign prev_slot = slots[i-1];
      assign ins_in    = ins_flag[i-1];
      assign seen_in   = seen[i-1];
    end

    if (i == MAX_ACTIVE - 1) begin : g_last
      assign next_slot = SLOT_EMPTY;
    end else begin : g_body
      assign next_slot = slots[i+1];
    end

    edfs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .prev_slot (prev_slot),
      .next_slot (next_slot),
      .ins_in    (ins_in),
      .seen_in   (seen_in),
      .slot      (slots[i]),
      .ins_out   (ins_flag[i]),
      .seen_out  (seen[i])
    );

    assign valid_vec[i] = slots[i].valid;
  end

  assign head_valid      = slots[0].valid;
  assign head_task_id    = slots[0].valid ? slots[0].task_id : 8'd0;
  assign head_deadline   = slots[0].valid ? slots[0].deadline : 32'd0;
  assign active_count    = 5'(count);
  assign completed_count = 16'(done_total);
  assign overdue_count   = 16'(late_total);

  `EDFS_ASSERT(a_count_matches_chain, $countones(valid_vec) == int'(count), "bad count")
  `EDFS_ASSERT(a_exec_then_done, busy |=> done, "execute cycle not followed by result strobe")
  `EDFS_ASSERT_ALWAYS(a_done_not_busy, !(done && busy), "result strobe during execute cycle")
  `EDFS_ASSERT(a_chain_packed, (!slots[0].valid) |-> (valid_vec == '0), "chain has a hole")

endmodule
`default_nettype wire
